### rtl/buddy_block_allocator_top_assert.svh
// Assertion macros for the buddy block allocator.
// Expects clk and rst in the scope of each use.
`ifndef BUDDY_BLOCK_ALLOCATOR_TOP_ASSERT_SVH
`define BUDDY_BLOCK_ALLOCATOR_TOP_ASSERT_SVH

// Property that holds at every edge outside reset.
`define BBA_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same-cycle implication.
`define BBA_CHECK_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define BBA_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/bba_pkg.sv
// Shared constants, types and helpers of the buddy block allocator.
// No dependencies; used by bba_ctrl, bba_dp and buddy_block_allocator_top.
`timescale 1ns / 1ps

package bba_pkg;

  localparam int MAX_ORDER  = 5;
  localparam int LIST_DEPTH = 32;
  localparam int ID_W       = 16;
  localparam int SIZE_W     = 16;
  localparam int ORD_W      = 3;
  localparam int IDX_W      = $clog2(LIST_DEPTH);
  localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
  localparam int NEED_W     = $clog2(SIZE_W + 1);
  localparam int STAT_W     = 2;

  localparam int IN_DATA_W  = ((ID_W + SIZE_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((CNT_W + ID_W + 7) / 8) * 8;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [STAT_W-1:0] ST_ALLOC = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOFIT = 2'd1;
  localparam logic [STAT_W-1:0] ST_ENTRY = 2'd2;

  // Controller to datapath
  typedef struct packed {
    logic start;       // latch request, rewind index
    logic idx_inc;     // advance list index
    logic take_pos;    // record hit position
    logic set_fail;    // mark no fit
    logic split_step;  // halve block at pos, shift tail back by one
    logic set_owner;   // write id into block at pos
    logic emit_result; // load allocate result into output register
    logic emit_entry;  // load list entry into output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_query;    // op of the pending request
    logic hit;         // entry at index is free and large enough
    logic room;        // splitting the hit keeps the list within depth
    logic at_end;      // index is on the last block
    logic need_split;  // block at pos still above needed order
    logic out_free;    // output register can take a result this cycle
  } sts_t;

  // ceil(log2(size)), zero for sizes 0 and 1
  function automatic logic [NEED_W-1:0] need_order(input logic [SIZE_W-1:0] size);
    logic [SIZE_W-1:0] v;
    logic [NEED_W-1:0] res;
    v   = size - 1'b1;
    res = '0;
    if (size > 1) begin
      for (int i = 0; i < SIZE_W; i++) begin
        if (v[i]) res = NEED_W'(i + 1);
      end
    end
    return res;
  endfunction

  function automatic logic [ORD_W-1:0] sat_order(input logic [ORD_W-1:0] v);
    return (v > ORD_W'(MAX_ORDER)) ? ORD_W'(MAX_ORDER) : v;
  endfunction

endpackage

### rtl/bba_ctrl.sv
// Sequencer of the buddy block allocator: scan, split, emit and query walk.
// Depends on bba_pkg.
`timescale 1ns / 1ps

module bba_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  bba_pkg::sts_t sts,
  output bba_pkg::cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SPLIT,
    S_EMIT,
    S_QUERY
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start  = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.is_query) begin
          state_next = S_QUERY;
        end else if (sts.hit) begin
          if (sts.room) begin
            cmd.take_pos = 1'b1;
            state_next   = S_SPLIT;
          end else begin
            cmd.set_fail = 1'b1;
            state_next   = S_EMIT;
          end
        end else if (sts.at_end) begin
          cmd.set_fail = 1'b1;
          state_next   = S_EMIT;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_SPLIT: begin
        if (sts.need_split) begin
          cmd.split_step = 1'b1;
        end else begin
          cmd.set_owner = 1'b1;
          state_next    = S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit_result = 1'b1;
          state_next      = S_IDLE;
        end
      end
      S_QUERY: begin
        if (sts.out_free) begin
          cmd.emit_entry = 1'b1;
          if (sts.at_end) begin
            state_next = S_IDLE;
          end else begin
            cmd.idx_inc = 1'b1;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

### rtl/bba_dp.sv
// Datapath of the buddy block allocator: block list, index, output register.
// Depends on bba_pkg and buddy_block_allocator_top_assert.svh.
`timescale 1ns / 1ps
`include "buddy_block_allocator_top_assert.svh"

module bba_dp (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [bba_pkg::ORD_W-1:0]          cfg_order,
  input  logic                               in_op,
  input  logic [bba_pkg::ID_W-1:0]           in_owner,
  input  logic [bba_pkg::SIZE_W-1:0]         in_size,
  input  bba_pkg::cmd_t                      cmd,
  output bba_pkg::sts_t                      sts,
  input  logic                               out_ready,
  output logic                               out_valid,
  output logic [bba_pkg::STAT_W-1:0]         out_status,
  output logic [bba_pkg::CNT_W-1:0]          out_total,
  output logic [bba_pkg::ID_W-1:0]           out_owner,
  output logic                               out_last
);

  logic [bba_pkg::ORD_W-1:0]  order_list [bba_pkg::LIST_DEPTH];
  logic [bba_pkg::ID_W-1:0]   owner_list [bba_pkg::LIST_DEPTH];
  logic [bba_pkg::CNT_W-1:0]  count;
  logic [bba_pkg::IDX_W-1:0]  idx;
  logic [bba_pkg::IDX_W-1:0]  pos;
  logic [bba_pkg::IDX_W-1:0]  pos_nxt;
  logic [bba_pkg::ORD_W-1:0]  pos_order;
  logic [bba_pkg::NEED_W-1:0] need;
  logic [bba_pkg::ID_W-1:0]   owner;
  logic                       op;
  logic                       fail;
  logic [bba_pkg::ORD_W-1:0]  init_order;
  logic [bba_pkg::ORD_W-1:0]  idx_order;
  logic [bba_pkg::ID_W-1:0]   idx_owner;
  logic [bba_pkg::ORD_W-1:0]  splits;
  logic [bba_pkg::CNT_W:0]    grown;
  logic                       out_load;

  assign idx_order  = order_list[idx];
  assign idx_owner  = owner_list[idx];
  assign pos_nxt    = pos + 1'b1;
  assign init_order = rst ? bba_pkg::ORD_W'(bba_pkg::MAX_ORDER)
                          : bba_pkg::sat_order(cfg_order);
  assign splits     = idx_order - need[bba_pkg::ORD_W-1:0];
  assign grown      = {1'b0, count} + (bba_pkg::CNT_W + 1)'(splits);
  assign out_load   = cmd.emit_result | cmd.emit_entry;

  always_comb begin
    sts            = '0;
    sts.is_query   = (op == bba_pkg::OP_QUERY);
    sts.hit        = (idx_owner == '0) &&
                     ({{(bba_pkg::NEED_W - bba_pkg::ORD_W){1'b0}}, idx_order} >= need);
    sts.room       = (grown <= (bba_pkg::CNT_W + 1)'(bba_pkg::LIST_DEPTH));
    sts.at_end     = (({1'b0, idx} + 1'b1) == count);
    sts.need_split = ({{(bba_pkg::NEED_W - bba_pkg::ORD_W){1'b0}}, pos_order} > need);
    sts.out_free   = !out_valid || out_ready;
  end

  // Request registers and walk index
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op    <= in_op;
      owner <= in_owner;
      need  <= bba_pkg::need_order(in_size);
      idx   <= '0;
      fail  <= 1'b0;
    end else if (cmd.idx_inc) begin
      idx <= idx + 1'b1;
    end
    if (cmd.set_fail) fail <= 1'b1;
    if (cmd.take_pos) begin
      pos       <= idx;
      pos_order <= idx_order;
    end else if (cmd.split_step) begin
      pos_order <= pos_order - 1'b1;
    end
  end

  // Block list: each split moves the tail back one slot
  always_ff @(posedge clk) begin
    if (cmd.split_step) begin
      for (int k = 1; k < bba_pkg::LIST_DEPTH; k++) begin
        if ((bba_pkg::CNT_W'(k) > ({1'b0, pos} + 1'b1)) && (bba_pkg::CNT_W'(k) <= count)) begin
          order_list[k] <= order_list[k-1];
          owner_list[k] <= owner_list[k-1];
        end
      end
      order_list[pos]     <= pos_order - 1'b1;
      order_list[pos_nxt] <= pos_order - 1'b1;
      owner_list[pos_nxt] <= '0;
    end
    if (cmd.set_owner) owner_list[pos] <= owner;
    if (rst || cfg_we) begin
      order_list[0] <= init_order;
      owner_list[0] <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      count <= bba_pkg::CNT_W'(1);
    end else if (cmd.split_step) begin
      count <= count + 1'b1;
    end
  end

  // Output register: holds a result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_result) begin
      out_status <= fail ? bba_pkg::ST_NOFIT : bba_pkg::ST_ALLOC;
      out_total  <= count;
      out_owner  <= '0;
      out_last   <= 1'b1;
    end else if (cmd.emit_entry) begin
      out_status <= bba_pkg::ST_ENTRY;
      out_total  <= count;
      out_owner  <= idx_owner;
      out_last   <= sts.at_end;
    end
  end

  `BBA_CHECK(a_count_range, (count != '0) && (count <= bba_pkg::CNT_W'(bba_pkg::LIST_DEPTH)), "block count out of range")
  `BBA_CHECK_NEXT(a_split_grows, cmd.split_step && !cfg_we, count == $past(count) + 1'b1, "split did not add one block")
  `BBA_CHECK_NOW(a_load_when_free, out_load, sts.out_free, "result loaded over a pending one")

endmodule

### rtl/buddy_block_allocator_top.sv
// Channel  | Signals                                  | Contents (low bits first)
// s_axis   | tvalid tready tdata[31:0] tuser[0]       | owner_id, request_size; tuser op
// m_axis   | tvalid tready tdata[23:0] tuser[1:0] tlast | block_total, entry_owner; tuser status
// cfg      | cfg_valid cfg_ready cfg_data[2:0]        | total_order (above 5 saturates)
//
// Allocate: scans the list for a free block large enough, splits it down to the needed order
// and writes the owner; reports no fit when none fits or the splits would exceed 32 blocks.
// Query: the request is latched, then one result per block per cycle while m_axis_tready is high.
// Reset (rst, synchronous) restores one free block of order 5; a cfg write restores one of order cfg_data.
// A stalled result sits in the output register while the next request is taken in.
// Depends on bba_pkg, bba_ctrl and bba_dp.
`timescale 1ns / 1ps

module buddy_block_allocator_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [bba_pkg::IN_DATA_W-1:0]    s_axis_tdata,   // owner_id, request_size
  input  logic                             s_axis_tuser,   // op
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [bba_pkg::OUT_DATA_W-1:0]   m_axis_tdata,   // block_total, entry_owner, zero fill
  output logic [bba_pkg::STAT_W-1:0]       m_axis_tuser,   // status
  output logic                             m_axis_tlast,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bba_pkg::ORD_W-1:0]        cfg_data
);

  bba_pkg::cmd_t              cmd;
  bba_pkg::sts_t              sts;
  logic [bba_pkg::CNT_W-1:0]  out_total;
  logic [bba_pkg::ID_W-1:0]   out_owner;

  assign cfg_ready = 1'b1;

  bba_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bba_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_valid & cfg_ready),
    .cfg_order  (cfg_data),
    .in_op      (s_axis_tuser),
    .in_owner   (s_axis_tdata[bba_pkg::ID_W-1:0]),
    .in_size    (s_axis_tdata[bba_pkg::ID_W +: bba_pkg::SIZE_W]),
    .cmd        (cmd),
    .sts        (sts),
    .out_ready  (m_axis_tready),
    .out_valid  (m_axis_tvalid),
    .out_status (m_axis_tuser),
    .out_total  (out_total),
    .out_owner  (out_owner),
    .out_last   (m_axis_tlast)
  );

  assign m_axis_tdata = bba_pkg::OUT_DATA_W'({out_owner, out_total});

endmodule
